// ===== rtl/msx_fsk_tape_demodulator_core_assert.svh =====
// Assertion macros for the tape demodulator.
`ifndef MSX_FSK_TAPE_DEMODULATOR_CORE_ASSERT_SVH
`define MSX_FSK_TAPE_DEMODULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSXFSK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSXFSK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSXFSK_ASSERT(lbl, clk, rst, prop, msg)
`define MSXFSK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/msxfsk_pkg.sv =====
`default_nettype none
package msxfsk_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DET,
    S_SAMP,
    S_CHK,
    S_ERR,
    S_UPD,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CFG_SILENCE_GAP  = 3'd0,
    CFG_BLOCK_GAP    = 3'd1,
    CFG_CARRIER_MIN  = 3'd2,
    CFG_CARRIER_MAX  = 3'd3,
    CFG_BAUD_SPLIT   = 3'd4,
    CFG_PHASE_WINDOW = 3'd5
  } cfg_index_t;

  localparam logic [1:0] BAUD_NONE = 2'd0;
  localparam logic [1:0] BAUD_SLOW = 2'd1;
  localparam logic [1:0] BAUD_FAST = 2'd2;

  localparam logic [3:0] BITPOS_START = 4'hF;  // -1: start bit window
  localparam logic [3:0] BITPOS_STOP  = 4'd8;

  localparam logic [10:0] WIN_2400 = 11'd416;
  localparam logic [10:0] WIN_1200 = 11'd833;
  localparam logic [15:0] SPACE_2400 = 16'd156;
  localparam logic [15:0] SPACE_1200 = 16'd312;
  localparam logic [17:0] DPLL_LO_2400 = 18'd312;
  localparam logic [17:0] DPLL_HI_2400 = 18'd520;
  localparam logic [17:0] DPLL_LO_1200 = 18'd625;
  localparam logic [17:0] DPLL_HI_1200 = 18'd1041;

  localparam logic [15:0] RST_SILENCE_GAP  = 16'd2000;
  localparam logic [23:0] RST_BLOCK_GAP    = 24'd1000000;
  localparam logic [9:0]  RST_CARRIER_MIN  = 10'd100;
  localparam logic [9:0]  RST_CARRIER_MAX  = 10'd550;
  localparam logic [9:0]  RST_BAUD_SPLIT   = 10'd312;
  localparam logic [7:0]  RST_PHASE_WINDOW = 8'd100;

  localparam int SIG_LEN = 8;

  typedef struct packed {
    logic       start;
    logic       sig;
    logic [7:0] data;
  } emit_req_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h1F;
      3'd1: b = 8'hA6;
      3'd2: b = 8'hDE;
      3'd3: b = 8'hBA;
      3'd4: b = 8'hCC;
      3'd5: b = 8'h13;
      3'd6: b = 8'h7D;
      3'd7: b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/msxfsk_if.sv =====
`default_nettype none
interface msxfsk_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        level_high;
  logic [25:0] duration_us;
  modport source (output valid, cmd, level_high, duration_us, input ready);
  modport sink (input valid, cmd, level_high, duration_us, output ready);
endinterface

interface msxfsk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last;
  modport source (output valid, byte_value, last, input ready);
  modport sink (input valid, byte_value, last, output ready);
endinterface

interface msxfsk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/msxfsk_emit.sv =====
`default_nettype none
// Result sequencer: optional block signature, then the data byte.
module msxfsk_emit (
  input  wire                  clk,
  input  wire                  rst,
  input  msxfsk_pkg::emit_req_t req,
  output logic                 busy,
  msxfsk_out_if.source         out_ch
);
  logic [3:0] idx;
  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      idx  <= req.sig ? 4'd0 : 4'(msxfsk_pkg::SIG_LEN);
    end else if (busy && out_ch.ready) begin
      if (idx == 4'(msxfsk_pkg::SIG_LEN)) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      data <= req.data;
    end
  end

  always_comb begin
    out_ch.valid = busy;
    if (idx[3]) begin
      out_ch.byte_value = data;
      out_ch.last       = 1'b1;
    end else begin
      out_ch.byte_value = msxfsk_pkg::sig_byte(idx[2:0]);
      out_ch.last       = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/msx_fsk_tape_demodulator_core.sv =====
`default_nettype none
`include "msx_fsk_tape_demodulator_core_assert.svh"
// MSX cassette FSK demodulator. Each input transaction is a timed tape
// half-wave (cmd 0) or a silence gap (cmd 1); result transactions carry
// decoded bytes, preceded by the 8-byte block signature after a long pause
// or before the first byte, with last set on the data byte. A half-wave
// passes the idle and detect states when it only pairs half-waves or hunts
// for carrier. While a frame is received it also passes the sample and
// check states, and the error, update, sample and check states again for
// each bit window it closes (usually 0 or 1); closing a byte waits for the
// result sequencer to drain the previous byte. The window sequencer walks
// one bit window per pass through shared 49-bit time adders/comparators and
// a phase-error unit. Silence gaps are handled in the idle state. Configuration writes are accepted in
// any cycle out of reset and must only happen while the block is idle.
module msx_fsk_tape_demodulator_core #(
  parameter int CARRIER_CYCLES = 16
) (
  input  wire           clk,
  input  wire           rst,
  msxfsk_in_if.sink     in_ch,
  msxfsk_out_if.source  out_ch,
  msxfsk_cfg_if.sink    cfg
);
  localparam int SUM_W = $clog2(CARRIER_CYCLES * 1024);
  localparam int CNT_W = $clog2(CARRIER_CYCLES + 1);

  // configuration
  logic [15:0] silence_gap;
  logic [23:0] block_gap;
  logic [9:0]  carrier_min;
  logic [9:0]  carrier_max;
  logic [9:0]  baud_split;
  logic [7:0]  phase_window;

  // detector state
  msxfsk_pkg::state_t state, state_next;
  logic [47:0]      time_now;
  logic [47:0]      last_edge;
  logic [47:0]      window_start;
  logic [47:0]      byte_stamp;
  logic [47:0]      first_space;
  logic [1:0]       baud_mode;
  logic             carrier_found;
  logic [CNT_W-1:0] mark_count;
  logic [SUM_W-1:0] mark_sum;
  logic             half_pending;
  logic             pending_level;
  logic [15:0]      pending_len;
  logic [10:0]      window_len;
  logic             rx_active;
  logic [1:0]       start_count;
  logic [3:0]       bit_pos;
  logic [7:0]       shift_byte;
  logic             sample_done;
  logic             sample_bit;

  // per-transaction work registers
  logic [16:0]      full;
  logic [15:0]      dur;
  logic             space_hw;
  logic signed [50:0] e1;
  logic signed [50:0] e2;

  logic                   accept;
  logic                   emit_busy;
  msxfsk_pkg::emit_req_t  emit_req;

  assign accept    = in_ch.valid && in_ch.ready;
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_gap  <= msxfsk_pkg::RST_SILENCE_GAP;
      block_gap    <= msxfsk_pkg::RST_BLOCK_GAP;
      carrier_min  <= msxfsk_pkg::RST_CARRIER_MIN;
      carrier_max  <= msxfsk_pkg::RST_CARRIER_MAX;
      baud_split   <= msxfsk_pkg::RST_BAUD_SPLIT;
      phase_window <= msxfsk_pkg::RST_PHASE_WINDOW;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        msxfsk_pkg::CFG_SILENCE_GAP:  silence_gap  <= cfg.data[15:0];
        msxfsk_pkg::CFG_BLOCK_GAP:    block_gap    <= cfg.data;
        msxfsk_pkg::CFG_CARRIER_MIN:  carrier_min  <= cfg.data[9:0];
        msxfsk_pkg::CFG_CARRIER_MAX:  carrier_max  <= cfg.data[9:0];
        msxfsk_pkg::CFG_BAUD_SPLIT:   baud_split   <= cfg.data[9:0];
        msxfsk_pkg::CFG_PHASE_WINDOW: phase_window <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // ---- shared combinational helpers ----
  logic        is_2400;
  logic [15:0] space_thr;
  logic [17:0] dpll_lo;
  logic [17:0] dpll_hi;
  assign is_2400   = (baud_mode == msxfsk_pkg::BAUD_FAST);
  assign space_thr = is_2400 ? msxfsk_pkg::SPACE_2400 : msxfsk_pkg::SPACE_1200;
  assign dpll_lo   = is_2400 ? msxfsk_pkg::DPLL_LO_2400 : msxfsk_pkg::DPLL_LO_1200;
  assign dpll_hi   = is_2400 ? msxfsk_pkg::DPLL_HI_2400 : msxfsk_pkg::DPLL_HI_1200;

  // pairing of half-waves
  logic        silence;
  logic [16:0] pend_sum;
  assign silence  = in_ch.cmd || (in_ch.duration_us > {10'd0, silence_gap});
  assign pend_sum = {1'b0, pending_len} + {1'b0, in_ch.duration_us[15:0]};

  // carrier hunt
  logic             mark_hit;
  logic [CNT_W-1:0] count_inc;
  logic [SUM_W-1:0] sum_inc;
  logic [SUM_W-1:0] split_prod;
  assign mark_hit   = (full > {7'd0, carrier_min}) && (full < {7'd0, carrier_max});
  assign count_inc  = mark_count + CNT_W'(1);
  assign sum_inc    = mark_sum + SUM_W'(full);
  assign split_prod = SUM_W'(baud_split) * SUM_W'(CARRIER_CYCLES);

  // window averaging while idle
  logic [17:0] est;
  logic [18:0] wl_mix;
  assign est    = (full >= {space_thr, 1'b0}) ? {1'b0, full} : {full, 1'b0};
  assign wl_mix = 19'({window_len, 4'd0}) - 19'(window_len) + {1'b0, est};

  // start bit hunt
  logic [1:0] start_inc;
  assign start_inc = (start_count == 2'd3) ? 2'd3 : start_count + 2'd1;

  // window unit: 49-bit window-end and mid-point adders, reused each pass
  logic [48:0] win_end;
  logic [48:0] mid_point;
  logic        mid_hit;
  logic        sb;
  assign win_end   = {1'b0, window_start} + 49'(window_len);
  assign mid_point = {1'b0, window_start} + 49'(window_len[10:1]);
  assign mid_hit   = ({1'b0, last_edge} <= mid_point) && ({1'b0, time_now} > mid_point);
  assign sb        = sample_done ? sample_bit : !space_hw;

  // phase error pick and correction
  logic [50:0] a1;
  logic [50:0] a2;
  logic [50:0] amin;
  logic        pe_neg;
  logic [47:0] corr;
  assign a1     = e1[50] ? 51'(-e1) : 51'(e1);
  assign a2     = e2[50] ? 51'(-e2) : 51'(e2);
  assign amin   = (a1 < a2) ? a1 : a2;
  assign pe_neg = (a1 < a2) ? e1[50] : e2[50];
  assign corr   = pe_neg ? -48'(amin[7:3]) : 48'(amin[7:3]);

  logic need_sig;
  assign need_sig = (byte_stamp == 48'd0) ||
                    ((time_now - byte_stamp) > {24'd0, block_gap});

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      msxfsk_pkg::S_IDLE: begin
        if (accept && !silence) state_next = msxfsk_pkg::S_DET;
      end
      msxfsk_pkg::S_DET: begin
        if (carrier_found && rx_active && full == 17'd0) begin
          state_next = msxfsk_pkg::S_SAMP;
        end else if (carrier_found && rx_active) begin
          state_next = msxfsk_pkg::S_SAMP;
        end else begin
          state_next = msxfsk_pkg::S_IDLE;
        end
      end
      msxfsk_pkg::S_SAMP: state_next = msxfsk_pkg::S_CHK;
      msxfsk_pkg::S_CHK: begin
        if ({1'b0, time_now} < win_end) begin
          state_next = msxfsk_pkg::S_IDLE;
        end else if (bit_pos == msxfsk_pkg::BITPOS_STOP) begin
          state_next = msxfsk_pkg::S_EMIT;
        end else if (bit_pos == msxfsk_pkg::BITPOS_START && sb) begin
          state_next = msxfsk_pkg::S_IDLE;
        end else begin
          state_next = msxfsk_pkg::S_ERR;
        end
      end
      msxfsk_pkg::S_ERR: state_next = msxfsk_pkg::S_UPD;
      msxfsk_pkg::S_UPD: state_next = msxfsk_pkg::S_SAMP;
      msxfsk_pkg::S_EMIT: begin
        if (!emit_busy) state_next = msxfsk_pkg::S_IDLE;
      end
      default: state_next = msxfsk_pkg::S_IDLE;
    endcase
  end

  // ---- outputs ----
  always_comb begin
    in_ch.ready    = (state == msxfsk_pkg::S_IDLE) && !rst;
    emit_req.start = (state == msxfsk_pkg::S_EMIT) && !emit_busy;
    emit_req.sig   = need_sig;
    emit_req.data  = shift_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= msxfsk_pkg::S_IDLE;
    else     state <= state_next;
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= 48'd0;
      last_edge      <= 48'd0;
      window_start   <= 48'd0;
      byte_stamp     <= 48'd0;
      first_space    <= 48'd0;
      baud_mode      <= msxfsk_pkg::BAUD_NONE;
      carrier_found  <= 1'b0;
      mark_count     <= '0;
      mark_sum       <= '0;
      half_pending   <= 1'b0;
      pending_level  <= 1'b0;
      pending_len    <= 16'd0;
      window_len     <= 11'd0;
      rx_active      <= 1'b0;
      start_count    <= 2'd0;
      bit_pos        <= 4'd0;
      shift_byte     <= 8'd0;
      sample_done    <= 1'b0;
      sample_bit     <= 1'b0;
    end else begin
      unique case (state)
        msxfsk_pkg::S_IDLE: begin
          if (accept) begin
            time_now <= time_now + 48'(in_ch.duration_us);
            if (silence) begin
              // drop all detection progress
              baud_mode     <= msxfsk_pkg::BAUD_NONE;
              rx_active     <= 1'b0;
              start_count   <= 2'd0;
              first_space   <= 48'd0;
              half_pending  <= 1'b0;
              pending_len   <= 16'd0;
              sample_done   <= 1'b0;
              sample_bit    <= 1'b0;
              mark_count    <= '0;
              mark_sum      <= '0;
              carrier_found <= 1'b0;
            end else begin
              last_edge <= time_now;
              full      <= 17'd0;
              if (!half_pending) begin
                pending_level <= in_ch.level_high;
                pending_len   <= in_ch.duration_us[15:0];
                half_pending  <= 1'b1;
              end else if (pending_level != in_ch.level_high) begin
                full          <= pend_sum;
                pending_level <= in_ch.level_high;
                pending_len   <= in_ch.duration_us[15:0];
              end else begin
                pending_len <= pend_sum[16] ? 16'hFFFF : pend_sum[15:0];
              end
            end
          end
        end
        msxfsk_pkg::S_DET: begin
          if (full != 17'd0 && !carrier_found) begin
            if (mark_hit) begin
              mark_count <= count_inc;
              mark_sum   <= sum_inc;
              if (count_inc >= CNT_W'(CARRIER_CYCLES)) begin
                if (sum_inc < split_prod) begin
                  baud_mode  <= msxfsk_pkg::BAUD_FAST;
                  window_len <= msxfsk_pkg::WIN_2400;
                end else begin
                  baud_mode  <= msxfsk_pkg::BAUD_SLOW;
                  window_len <= msxfsk_pkg::WIN_1200;
                end
                carrier_found <= 1'b1;
                rx_active     <= 1'b0;
              end
            end else begin
              mark_count <= '0;
              mark_sum   <= '0;
            end
          end else if (carrier_found) begin
            space_hw <= (dur >= space_thr);
            if (!rx_active) begin
              if (full != 17'd0 && est > dpll_lo && est < dpll_hi) begin
                window_len <= wl_mix[14:4];
              end
              if (dur >= space_thr) begin
                if (start_count == 2'd0) first_space <= last_edge;
                start_count <= start_inc;
                if (start_inc == 2'd2) begin
                  rx_active    <= 1'b1;
                  window_start <= (start_count == 2'd0) ? last_edge : first_space;
                  bit_pos      <= msxfsk_pkg::BITPOS_START;
                  sample_done  <= 1'b1;
                  sample_bit   <= 1'b0;
                end
              end else begin
                start_count <= 2'd0;
              end
            end
          end
        end
        msxfsk_pkg::S_SAMP: begin
          if (!sample_done && mid_hit) begin
            sample_bit  <= !space_hw;
            sample_done <= 1'b1;
          end
        end
        msxfsk_pkg::S_CHK: begin
          if ({1'b0, time_now} >= win_end) begin
            if (bit_pos == msxfsk_pkg::BITPOS_START) begin
              if (sb) begin
                rx_active <= 1'b0;
              end else begin
                bit_pos    <= 4'd0;
                shift_byte <= 8'd0;
              end
            end else if (bit_pos != msxfsk_pkg::BITPOS_STOP) begin
              if (sb) shift_byte[bit_pos[2:0]] <= 1'b1;
              bit_pos <= bit_pos + 4'd1;
            end
          end
        end
        msxfsk_pkg::S_ERR: begin
          e1 <= $signed({3'd0, last_edge}) - $signed({2'd0, win_end});
          e2 <= $signed({3'd0, time_now}) - $signed({2'd0, win_end});
        end
        msxfsk_pkg::S_UPD: begin
          // nudge the window by one eighth of a small phase error
          if (amin < 51'(phase_window)) begin
            window_start <= win_end[47:0] + corr;
          end else begin
            window_start <= win_end[47:0];
          end
          sample_done <= 1'b0;
          sample_bit  <= 1'b0;
        end
        msxfsk_pkg::S_EMIT: begin
          if (!emit_busy) begin
            rx_active  <= 1'b0;
            byte_stamp <= time_now;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == msxfsk_pkg::S_IDLE && accept) dur <= in_ch.duration_us[15:0];
  end

  msxfsk_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .req    (emit_req),
    .busy   (emit_busy),
    .out_ch (out_ch)
  );

  `MSXFSK_ASSERT(a_emit_free, clk, rst, emit_req.start |-> !emit_busy, "emit while busy")
  `MSXFSK_ASSERT(a_emit_frame, clk, rst, state == msxfsk_pkg::S_EMIT |-> rx_active && bit_pos == msxfsk_pkg::BITPOS_STOP, "emit outside stop window")
  `MSXFSK_ASSERT(a_gap_clears, clk, rst, accept && in_ch.cmd |=> !carrier_found && !rx_active && state == msxfsk_pkg::S_IDLE, "gap kept detection")
  `MSXFSK_ASSERT(a_bitpos_range, clk, rst, rx_active |-> bit_pos <= msxfsk_pkg::BITPOS_STOP || bit_pos == msxfsk_pkg::BITPOS_START, "bit position out of range")
endmodule
`default_nettype wire

// ===== sim/msx_fsk_tape_demodulator_core_tb.sv =====
`default_nettype none
module msx_fsk_tape_demodulator_core_tb;

  localparam int MARK_PERIODS = 16;
  localparam longint unsigned T48 = 64'hFFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 2000;
  localparam int RANDOM_UNTIL = 430;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  msxfsk_in_if  in_ch ();
  msxfsk_out_if out_ch ();
  msxfsk_cfg_if cfg ();

  msx_fsk_tape_demodulator_core #(.CARRIER_CYCLES(MARK_PERIODS)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // Expected result transactions: {last, byte_value}, oldest first.
  logic [8:0] byte_q[$];
  int err_count = 0;
  int items_sent = 0;
  bit quiet_in = 0;   // when set, the sender never idles
  bit quiet_out = 0;  // when set, the receiver never stalls
  bit tape_level = 0; // polarity of the next synthesized half-wave

  // Demodulator shadow: configuration.
  logic [15:0] sil_gap;
  logic [23:0] blk_gap;
  logic [9:0]  car_min, car_max, split_us;
  logic [7:0]  ph_win;

  // Demodulator shadow: state. Times are held 48 bits wide in 64-bit vars.
  longint unsigned t_now, t_edge, win_start, t_byte, t_space;
  logic [1:0] baud;
  bit carrier, half_pend, pend_lvl, rx_on, samp_done, samp_bit;
  int mcount, msum, pend_len, win_len, space_cnt, bitpos;
  logic [7:0] shreg;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic clear_detect();
    baud = msxfsk_pkg::BAUD_NONE;
    rx_on = 0;
    space_cnt = 0;
    t_space = 0;
    half_pend = 0;
    pend_len = 0;
    samp_done = 0;
    samp_bit = 0;
    mcount = 0;
    msum = 0;
    carrier = 0;
  endtask

  task automatic reset_shadow();
    sil_gap = msxfsk_pkg::RST_SILENCE_GAP;
    blk_gap = msxfsk_pkg::RST_BLOCK_GAP;
    car_min = msxfsk_pkg::RST_CARRIER_MIN;
    car_max = msxfsk_pkg::RST_CARRIER_MAX;
    split_us = msxfsk_pkg::RST_BAUD_SPLIT;
    ph_win = msxfsk_pkg::RST_PHASE_WINDOW;
    t_now = 0; t_edge = 0; win_start = 0; t_byte = 0;
    win_len = 0; bitpos = 0; shreg = 0; pend_lvl = 0;
    clear_detect();
  endtask

  // Queue the block signature when the pause since the last byte is long,
  // then the data byte itself.
  task automatic emit_byte();
    if (t_byte == 0 || ((t_now - t_byte) & T48) > longint'(blk_gap)) begin
      for (int k = 0; k < msxfsk_pkg::SIG_LEN; k++) begin
        case (k)
          0: byte_q.push_back({1'b0, 8'h1F});
          1: byte_q.push_back({1'b0, 8'hA6});
          2: byte_q.push_back({1'b0, 8'hDE});
          3: byte_q.push_back({1'b0, 8'hBA});
          4: byte_q.push_back({1'b0, 8'hCC});
          5: byte_q.push_back({1'b0, 8'h13});
          6: byte_q.push_back({1'b0, 8'h7D});
          default: byte_q.push_back({1'b0, 8'h74});
        endcase
      end
    end
    byte_q.push_back({1'b1, shreg});
    t_byte = t_now;
  endtask

  // Advance the shadow demodulator by one tape transaction.
  task automatic demod_step(bit c, bit lv, logic [25:0] d);
    longint unsigned dur, full, est, bp, st, tgt, sp_thr, lo, hi;
    longint e1, e2, a1, a2, pe, nxt;
    bit spc;
    dur = d;
    full = 0;
    if (c || dur > sil_gap) begin
      clear_detect();
      t_now = (t_now + dur) & T48;
      return;
    end
    if (!half_pend) begin
      pend_lvl = lv; pend_len = int'(dur); half_pend = 1;
    end else if (pend_lvl != lv) begin
      full = pend_len + dur; pend_lvl = lv; pend_len = int'(dur);
    end else begin
      pend_len += int'(dur);
      if (pend_len > 65535) pend_len = 65535;
    end
    t_edge = t_now;
    t_now = (t_now + dur) & T48;
    sp_thr = (baud == msxfsk_pkg::BAUD_FAST) ? 156 : 312;
    lo = (baud == msxfsk_pkg::BAUD_FAST) ? 312 : 625;
    hi = (baud == msxfsk_pkg::BAUD_FAST) ? 520 : 1041;
    if (full > 0) begin
      // Hunt for a steady mark tone, then pick the baud from its period.
      if (!carrier) begin
        if (full > car_min && full < car_max) begin
          mcount++;
          msum += int'(full);
          if (mcount >= MARK_PERIODS) begin
            if (msum / MARK_PERIODS < split_us) begin
              baud = msxfsk_pkg::BAUD_FAST; win_len = int'(msxfsk_pkg::WIN_2400);
            end else begin
              baud = msxfsk_pkg::BAUD_SLOW; win_len = int'(msxfsk_pkg::WIN_1200);
            end
            carrier = 1;
            rx_on = 0;
          end
        end else begin
          mcount = 0; msum = 0;
        end
        return;
      end
      // Track the bit window while idle.
      if (!rx_on) begin
        est = (full >= sp_thr * 2) ? full : full * 2;
        if (est > lo && est < hi) win_len = int'((win_len * 15 + est) / 16);
      end
    end
    if (!carrier) return;
    spc = dur >= sp_thr;
    if (!rx_on) begin
      // Two space half-waves in a row open a frame.
      if (spc) begin
        if (space_cnt == 0) t_space = t_edge;
        if (space_cnt < 3) space_cnt++;
        if (space_cnt == 2) begin
          rx_on = 1; win_start = t_space; bitpos = -1;
          samp_done = 1; samp_bit = 0;
        end
      end else begin
        space_cnt = 0;
      end
      return;
    end
    bp = win_len;
    st = win_start + bp / 2;
    if (!samp_done && t_edge <= st && t_now > st) begin
      samp_bit = !spc; samp_done = 1;
    end
    // Close every bit window that this half-wave crosses.
    while (t_now >= win_start + bp) begin
      if (!samp_done) samp_bit = !spc;
      if (bitpos == -1) begin
        if (samp_bit) begin
          rx_on = 0;
          break;
        end
        bitpos = 0; shreg = 0;
      end else if (bitpos >= 0 && bitpos <= 7) begin
        if (samp_bit) shreg[bitpos] = 1'b1;
        bitpos++;
      end else if (bitpos == 8) begin
        rx_on = 0;
        emit_byte();
        return;
      end
      tgt = win_start + bp;
      e1 = longint'(t_edge) - longint'(tgt);
      e2 = longint'(t_now) - longint'(tgt);
      a1 = e1 < 0 ? -e1 : e1;
      a2 = e2 < 0 ? -e2 : e2;
      pe = (a1 < a2) ? e1 : e2;
      // Nudge the window toward the nearest edge when the error is small.
      if (pe > -longint'(ph_win) && pe < longint'(ph_win)) begin
        nxt = longint'(win_start) + longint'(bp) + pe / 8;
        win_start = longint'(nxt) & T48;
      end else begin
        win_start = (win_start + bp) & T48;
      end
      samp_done = 0; samp_bit = 0;
      st = win_start + bp / 2;
      if (t_edge <= st && t_now > st) begin
        samp_bit = !spc; samp_done = 1;
      end
    end
  endtask

  // Send one tape transaction; entered and left just after a rising edge.
  task automatic send_tape(bit c, bit lv, logic [25:0] d);
    int unsigned gap;
    gap = quiet_in ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.cmd = c;
    in_ch.level_high = lv;
    in_ch.duration_us = d;
    do @(posedge clk); while (!in_ch.ready);
    demod_step(c, lv, d);
    items_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Wait until every expected byte is out and the window sequencer is done.
  task automatic drain();
    hold_input();
    while (byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(msxfsk_pkg::cfg_index_t idx, logic [23:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      msxfsk_pkg::CFG_SILENCE_GAP:  sil_gap = val[15:0];
      msxfsk_pkg::CFG_BLOCK_GAP:    blk_gap = val;
      msxfsk_pkg::CFG_CARRIER_MIN:  car_min = val[9:0];
      msxfsk_pkg::CFG_CARRIER_MAX:  car_max = val[9:0];
      msxfsk_pkg::CFG_BAUD_SPLIT:   split_us = val[9:0];
      default:                      ph_win = val[7:0];
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic write_defaults();
    write_reg(msxfsk_pkg::CFG_SILENCE_GAP, 24'(msxfsk_pkg::RST_SILENCE_GAP));
    write_reg(msxfsk_pkg::CFG_BLOCK_GAP, msxfsk_pkg::RST_BLOCK_GAP);
    write_reg(msxfsk_pkg::CFG_CARRIER_MIN, 24'(msxfsk_pkg::RST_CARRIER_MIN));
    write_reg(msxfsk_pkg::CFG_CARRIER_MAX, 24'(msxfsk_pkg::RST_CARRIER_MAX));
    write_reg(msxfsk_pkg::CFG_BAUD_SPLIT, 24'(msxfsk_pkg::RST_BAUD_SPLIT));
    write_reg(msxfsk_pkg::CFG_PHASE_WINDOW, 24'(msxfsk_pkg::RST_PHASE_WINDOW));
  endtask

  task automatic half_wave(int len, int jit);
    int v;
    v = len + $urandom_range(0, 2 * jit) - jit;
    if (v < 0) v = 0;
    send_tape(1'b0, tape_level, 26'(v));
    tape_level = ~tape_level;
  endtask

  // One recorded bit: a space is one slow cycle, a mark two fast cycles.
  task automatic tape_bit(bit b, int h, int jit);
    if (b) repeat (4) half_wave(h, jit);
    else repeat (2) half_wave(2 * h, jit);
  endtask

  // Leader tone followed by UART frames, as a tape recorder plays them back.
  task automatic tape_block(bit fast, int nbytes, int jit);
    int h;
    logic [7:0] data;
    h = fast ? 104 : 208;
    repeat ($urandom_range(18, 24)) half_wave(h, jit);
    repeat (nbytes) begin
      data = 8'($urandom);
      tape_bit(1'b0, h, jit);
      for (int i = 0; i < 8; i++) tape_bit(data[i], h, jit);
      repeat ($urandom_range(2, 3)) tape_bit(1'b1, h, jit);
    end
    repeat ($urandom_range(2, 6)) half_wave(h, jit);
  endtask

  task automatic noise_item();
    int unsigned w;
    logic [25:0] d;
    w = $urandom_range(1, 26);
    d = 26'($urandom & ((32'd1 << w) - 1));
    send_tape($urandom_range(0, 4) == 0, 1'($urandom), d);
  endtask

  // Field extremes, silence, over-long and same-polarity pulses, then one
  // clean block at each baud rate at reset settings.
  task automatic test_edges();
    send_tape(1'b1, 1'b0, 26'h3FFFFFF);
    send_tape(1'b1, 1'b1, 26'd0);
    send_tape(1'b0, 1'b1, 26'd0);
    send_tape(1'b0, 1'b0, 26'd0);
    send_tape(1'b0, 1'b0, 26'h3FFFFFF);
    send_tape(1'b0, 1'b1, 26'd2000);
    send_tape(1'b0, 1'b1, 26'd2000);
    send_tape(1'b0, 1'b1, 26'd2001);
    send_tape(1'b0, 1'b0, 26'h2AAAAAA);
    send_tape(1'b0, 1'b1, 26'h1555555);
    tape_block(1'b0, 1, 0);
    tape_block(1'b1, 1, 0);
  endtask

  task automatic test_reg_extremes();
    drain();
    // Every pulse longer than zero counts as silence.
    write_reg(msxfsk_pkg::CFG_SILENCE_GAP, 24'd0);
    send_tape(1'b0, 1'b0, 26'd1);
    send_tape(1'b0, 1'b1, 26'd0);
    drain();
    // Widest pulses allowed: same-polarity lengths saturate.
    write_reg(msxfsk_pkg::CFG_SILENCE_GAP, 24'hFFFF);
    write_reg(msxfsk_pkg::CFG_BLOCK_GAP, 24'd0);
    write_reg(msxfsk_pkg::CFG_PHASE_WINDOW, 24'd0);
    repeat (3) send_tape(1'b0, 1'b1, 26'hFFFF);
    tape_block(1'b0, 2, 6);
    drain();
    write_reg(msxfsk_pkg::CFG_SILENCE_GAP, 24'(msxfsk_pkg::RST_SILENCE_GAP));
    write_reg(msxfsk_pkg::CFG_BLOCK_GAP, 24'hFFFFFF);
    write_reg(msxfsk_pkg::CFG_PHASE_WINDOW, 24'hFF);
    write_reg(msxfsk_pkg::CFG_CARRIER_MIN, 24'd0);
    write_reg(msxfsk_pkg::CFG_CARRIER_MAX, 24'h3FF);
    write_reg(msxfsk_pkg::CFG_BAUD_SPLIT, 24'h3FF);
    tape_block(1'b1, 1, 10);
    drain();
    // No period can count as carrier: a leader alone is enough.
    write_reg(msxfsk_pkg::CFG_BAUD_SPLIT, 24'd0);
    write_reg(msxfsk_pkg::CFG_CARRIER_MIN, 24'h3FF);
    repeat (24) half_wave(208, 5);
    drain();
    write_reg(msxfsk_pkg::CFG_CARRIER_MIN, 24'd0);
    write_reg(msxfsk_pkg::CFG_CARRIER_MAX, 24'd0);
    repeat (24) half_wave(104, 5);
    drain();
    write_defaults();
  endtask

  // Mostly well-formed tape with random content and timing jitter, with
  // noise and reconfiguration mixed in.
  task automatic test_random_tape();
    while (items_sent < RANDOM_UNTIL) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_reg(msxfsk_pkg::CFG_PHASE_WINDOW, 24'($urandom_range(20, 255)));
        write_reg(msxfsk_pkg::CFG_BLOCK_GAP,
                  $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 5000))
                                            : msxfsk_pkg::RST_BLOCK_GAP);
        write_reg(msxfsk_pkg::CFG_SILENCE_GAP, 24'($urandom_range(900, 65535)));
        quiet_in = $urandom_range(0, 3) == 0;
        quiet_out = $urandom_range(0, 3) == 0;
      end
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0) send_tape(1'b1, 1'($urandom), 26'($urandom));
        tape_block(1'($urandom), $urandom_range(1, 2), $urandom_range(0, 25));
      end else begin
        repeat ($urandom_range(1, 6)) noise_item();
      end
    end
    quiet_in = 0;
    quiet_out = 0;
  endtask

  // Receiver: random stalls at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= quiet_out ? 1'b1 : ($urandom_range(0, 99) < 70);
  end

  // Compare each result transaction with the oldest expected byte.
  always @(posedge clk) begin
    logic [8:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (byte_q.size() == 0) begin
        report_mismatch("unexpected byte", int'(out_ch.byte_value), 0);
      end else begin
        want = byte_q.pop_front();
        if (out_ch.byte_value !== want[7:0])
          report_mismatch("byte_value", int'(out_ch.byte_value), int'(want[7:0]));
        if (out_ch.last !== want[8])
          report_mismatch("last", int'(out_ch.last), int'(want[8]));
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.level_high = 1'b0;
    in_ch.duration_us = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = msxfsk_pkg::CFG_SILENCE_GAP;
    cfg.data = '0;
    reset_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    test_edges();
    test_reg_extremes();
    test_random_tape();
    drain();
    if (err_count == 0 && byte_q.size() == 0)
      $display("msx_fsk_tape_demodulator_core: match");
    else
      $display("msx_fsk_tape_demodulator_core: mismatch");
    $finish;
  end

  initial begin
    #20000000;
    $display("msx_fsk_tape_demodulator_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ===== msx_fsk_tape_demodulator_core.f =====
+incdir+rtl
rtl/msxfsk_pkg.sv
rtl/msxfsk_if.sv
rtl/msxfsk_emit.sv
rtl/msx_fsk_tape_demodulator_core.sv
sim/msx_fsk_tape_demodulator_core_tb.sv
